### rtl/core/mcr_pkg.sv
package mcr_pkg;

	localparam int COORD_BITS = 10;
	localparam int OFF_W      = COORD_BITS + 1;
	localparam int STEP_W     = COORD_BITS + 3;
	localparam int DEC_W      = COORD_BITS + 4;
	localparam int OUT_W      = 12;
	localparam int PIX_W      = (COORD_BITS + 3 > OUT_W) ? COORD_BITS + 3 : OUT_W;
	localparam int COLOR_W    = 16;
	localparam int SCR_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int IDX_W      = 3;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [SCR_W-1:0] WIDTH_RST  = 10'd320;
	localparam logic [SCR_W-1:0] HEIGHT_RST = 10'd240;

	localparam logic [IDX_W-1:0] AXIS_LAST = 3'd3;
	localparam logic [IDX_W-1:0] OCT_LAST  = 3'd7;

	typedef struct packed {
		logic                  axis;
		logic                  done;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [OFF_W-1:0]      ox;
		logic [OFF_W-1:0]      oy;
		logic [COLOR_W-1:0]    color;
	} grp_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [COLOR_W-1:0]      color;
		logic                    visible;
		logic                    last;
		logic                    done;
	} pix_t;

endpackage

### rtl/core/mcr_if.sv
interface mcr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [mcr_pkg::COORD_BITS-1:0] center_x;
	logic [mcr_pkg::COORD_BITS-1:0] center_y;
	logic [mcr_pkg::COORD_BITS-1:0] radius;
	logic [mcr_pkg::COLOR_W-1:0]    color;

	modport source (output valid, mode, center_x, center_y, radius, color, input ready);
	modport sink   (input valid, mode, center_x, center_y, radius, color, output ready);
endinterface

interface mcr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [mcr_pkg::OUT_W-1:0]    pixel_x;
	logic signed [mcr_pkg::OUT_W-1:0]    pixel_y;
	logic [mcr_pkg::COLOR_W-1:0]         pixel_color;
	logic                                visible;
	logic                                group_last;
	logic                                circle_done;

	modport source (output valid, pixel_x, pixel_y, pixel_color, visible, group_last,
		circle_done, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, group_last,
		circle_done, output ready);
endinterface

interface mcr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mcr_pkg::CFG_IDX_W-1:0]  index;
	logic [mcr_pkg::SCR_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mcr_step.sv
module mcr_step (
	input  logic          clk,
	input  logic          arst_n,
	mcr_in_if.sink        cmd,
	input  logic          grp_take,
	output logic          grp_vld,
	output mcr_pkg::grp_t grp
);

	logic                                   busy_q;
	logic                                   axis_q;
	logic [mcr_pkg::COORD_BITS-1:0]         cen_x_q;
	logic [mcr_pkg::COORD_BITS-1:0]         cen_y_q;
	logic [mcr_pkg::OFF_W-1:0]              off_x_q;
	logic [mcr_pkg::OFF_W-1:0]              off_y_q;
	logic signed [mcr_pkg::DEC_W-1:0]       dec_q;
	logic signed [mcr_pkg::STEP_W-1:0]      step_x_q;
	logic signed [mcr_pkg::STEP_W-1:0]      step_y_q;
	logic [mcr_pkg::COLOR_W-1:0]            color_q;
	logic                                   grp_vld_q;
	mcr_pkg::grp_t                          grp_q;

	logic                                   acc;
	logic                                   start;
	logic                                   load;
	logic                                   d_ge;
	logic [mcr_pkg::OFF_W-1:0]              ox_n;
	logic [mcr_pkg::OFF_W-1:0]              oy_n;
	logic signed [mcr_pkg::STEP_W-1:0]      sx_n;
	logic signed [mcr_pkg::STEP_W-1:0]      sy_n;
	logic signed [mcr_pkg::DEC_W-1:0]       d1;
	logic signed [mcr_pkg::DEC_W-1:0]       d_n;
	logic                                   axis_done;
	logic                                   oct_done;
	mcr_pkg::grp_t                          grp_d;

	assign cmd.ready = !grp_vld_q || grp_take;
	assign acc       = cmd.valid && cmd.ready;
	assign start     = acc && (cmd.mode == mcr_pkg::MODE_START);
	assign load      = acc && (cmd.mode == mcr_pkg::MODE_STEP) && busy_q;

	// one midpoint step: optional y move, then x move
	always_comb begin
		d_ge = !dec_q[mcr_pkg::DEC_W-1];
		sy_n = d_ge ? step_y_q + mcr_pkg::STEP_W'(2) : step_y_q;
		oy_n = d_ge ? off_y_q - mcr_pkg::OFF_W'(1) : off_y_q;
		d1   = d_ge ? dec_q + mcr_pkg::DEC_W'(sy_n) : dec_q;
		sx_n = step_x_q + mcr_pkg::STEP_W'(2);
		ox_n = off_x_q + mcr_pkg::OFF_W'(1);
		d_n  = d1 + mcr_pkg::DEC_W'(sx_n);
		axis_done = !(off_x_q < off_y_q);
		oct_done  = !(ox_n < oy_n);
	end

	always_comb begin
		grp_d.axis  = axis_q;
		grp_d.done  = axis_q ? axis_done : oct_done;
		grp_d.cx    = cen_x_q;
		grp_d.cy    = cen_y_q;
		grp_d.ox    = axis_q ? off_x_q : ox_n;
		grp_d.oy    = axis_q ? off_y_q : oy_n;
		grp_d.color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			axis_q    <= 1'b0;
			cen_x_q   <= '0;
			cen_y_q   <= '0;
			off_x_q   <= '0;
			off_y_q   <= '0;
			dec_q     <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			color_q   <= '0;
			grp_vld_q <= 1'b0;
		end else begin
			if (start) begin
				cen_x_q  <= cmd.center_x;
				cen_y_q  <= cmd.center_y;
				color_q  <= cmd.color;
				off_x_q  <= '0;
				off_y_q  <= mcr_pkg::OFF_W'(cmd.radius);
				dec_q    <= mcr_pkg::DEC_W'(1) - mcr_pkg::DEC_W'(cmd.radius);
				step_x_q <= mcr_pkg::STEP_W'(1);
				step_y_q <= -(mcr_pkg::STEP_W'(cmd.radius) <<< 1);
				busy_q   <= 1'b1;
				axis_q   <= 1'b1;
			end else if (load) begin
				if (axis_q) begin
					axis_q <= 1'b0;
					if (axis_done)
						busy_q <= 1'b0;
				end else begin
					off_x_q  <= ox_n;
					off_y_q  <= oy_n;
					step_x_q <= sx_n;
					step_y_q <= sy_n;
					dec_q    <= d_n;
					if (oct_done)
						busy_q <= 1'b0;
				end
			end
			if (load)
				grp_vld_q <= 1'b1;
			else if (grp_take)
				grp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			grp_q <= grp_d;
	end

	assign grp_vld = grp_vld_q;
	assign grp     = grp_q;

	a_axis_busy: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q |-> busy_q)
		else $error("axis group pending without a circle");

	a_load_grp: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> grp_vld_q)
		else $error("step beat did not fill the group register");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(load) && grp_vld_q && grp_q.done)
		else $error("circle ended without a final group");

endmodule

### rtl/core/mcr_emit.sv
module mcr_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        grp_vld,
	input  mcr_pkg::grp_t               grp,
	input  logic [mcr_pkg::SCR_W-1:0]   width,
	input  logic [mcr_pkg::SCR_W-1:0]   height,
	output logic                        grp_take,
	mcr_out_if.source                   pix
);

	logic [mcr_pkg::IDX_W-1:0]        idx_q;
	logic                             out_vld_q;
	mcr_pkg::pix_t                    out_q;

	logic                             out_free;
	logic                             adv;
	logic                             last;
	logic [mcr_pkg::IDX_W-1:0]        oi;
	logic [mcr_pkg::OFF_W-1:0]        a;
	logic [mcr_pkg::OFF_W-1:0]        b;
	logic signed [mcr_pkg::PIX_W-1:0] px;
	logic signed [mcr_pkg::PIX_W-1:0] py;
	mcr_pkg::pix_t                    pix_d;

	assign out_free = !out_vld_q || pix.ready;
	assign adv      = grp_vld && out_free;
	assign last     = idx_q == (grp.axis ? mcr_pkg::AXIS_LAST : mcr_pkg::OCT_LAST);
	assign grp_take = adv && last;

	// axis points reuse the octant pattern with x = 0
	always_comb begin
		if (grp.axis) begin
			case (idx_q)
				3'd0:    oi = 3'd0;
				3'd1:    oi = 3'd2;
				3'd2:    oi = 3'd4;
				default: oi = 3'd5;
			endcase
		end else begin
			oi = idx_q;
		end
		// bit 2 swaps x and y, bit 0 negates the column term, bit 1 the row term
		a  = oi[2] ? grp.oy : grp.ox;
		b  = oi[2] ? grp.ox : grp.oy;
		px = oi[0] ? mcr_pkg::PIX_W'(grp.cx) - mcr_pkg::PIX_W'(a)
			: mcr_pkg::PIX_W'(grp.cx) + mcr_pkg::PIX_W'(a);
		py = oi[1] ? mcr_pkg::PIX_W'(grp.cy) - mcr_pkg::PIX_W'(b)
			: mcr_pkg::PIX_W'(grp.cy) + mcr_pkg::PIX_W'(b);
		pix_d.x       = px[mcr_pkg::OUT_W-1:0];
		pix_d.y       = py[mcr_pkg::OUT_W-1:0];
		pix_d.color   = grp.color;
		pix_d.visible = !px[mcr_pkg::PIX_W-1] && !py[mcr_pkg::PIX_W-1]
			&& (px < $signed(mcr_pkg::PIX_W'(width)))
			&& (py < $signed(mcr_pkg::PIX_W'(height)));
		pix_d.last    = last;
		pix_d.done    = grp.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv)
				idx_q <= last ? '0 : idx_q + mcr_pkg::IDX_W'(1);
			if (adv)
				out_vld_q <= 1'b1;
			else if (pix.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= pix_d;
	end

	assign pix.valid       = out_vld_q;
	assign pix.pixel_x     = out_q.x;
	assign pix.pixel_y     = out_q.y;
	assign pix.pixel_color = out_q.color;
	assign pix.visible     = out_q.visible;
	assign pix.group_last  = out_q.last;
	assign pix.circle_done = out_q.done;

	a_idx_in_grp: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> grp_vld)
		else $error("pixel counter running with no group held");

	a_take_last: assert property (@(posedge clk) disable iff (!arst_n)
		grp_take |=> out_vld_q && out_q.last)
		else $error("group released without its last beat");

	a_axis_len: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_vld && grp.axis) |-> (idx_q <= mcr_pkg::AXIS_LAST))
		else $error("axis group ran past four pixels");

endmodule

### rtl/core/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer. A start beat (mode 0) loads centre, radius and colour and
// yields nothing; each step beat (mode 1) taken while a circle is in progress yields one
// pixel group: four axis points first, then eight mirrored points per step, each tagged
// visible when on screen. Step state is updated in the cycle the beat is taken and the
// group is parked in a single group register, from which the output register sends one
// pixel beat per cycle while the sink is ready. The next command beat is taken in the cycle
// the last pixel of the current group moves to the output register. Screen width and height
// are written through the config channel, which is always ready.
module midpoint_circle_rasterizer (
	input  logic      clk,
	input  logic      arst_n,
	mcr_in_if.sink    cmd,
	mcr_out_if.source pix,
	mcr_cfg_if.sink   cfg
);

	logic [mcr_pkg::SCR_W-1:0] width_q;
	logic [mcr_pkg::SCR_W-1:0] height_q;
	logic                      grp_vld;
	logic                      grp_take;
	mcr_pkg::grp_t             grp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mcr_pkg::WIDTH_RST;
			height_q <= mcr_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mcr_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg.data;
				mcr_pkg::REG_SCREEN_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	mcr_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.grp_take (grp_take),
		.grp_vld  (grp_vld),
		.grp      (grp)
	);

	mcr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_vld  (grp_vld),
		.grp      (grp),
		.width    (width_q),
		.height   (height_q),
		.grp_take (grp_take),
		.pix      (pix)
	);

endmodule
